// ===== sv/spas_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse pair argmin search: shared package
// Word layouts, field widths, operation and register codes, and the command
// and status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package spas_pkg;

    localparam int OP_W       = 2;
    localparam int SLOT_W     = 15;
    localparam int PTR_W      = 15;
    localparam int ROW_W      = 10;
    localparam int VAL_W      = 32;
    localparam int IDX_W      = 11;
    localparam int K_W        = IDX_W + 1;
    localparam int LAM_W      = 16;
    localparam int SUM_W      = VAL_W + 2;
    localparam int PROD_W     = LAM_W + SUM_W;
    localparam int SCORE_W    = PROD_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [OP_W-1:0] OP_LOAD_PTR   = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_ENTRY = 2'd1;
    localparam logic [OP_W-1:0] OP_START      = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd2;

    localparam logic signed [LAM_W-1:0] LAMBDA_RESET = 16'sd256;
    localparam logic [IDX_W-1:0]        DIM_RESET    = 11'd1024;
    localparam logic [IDX_W-1:0]        IDX_ONE      = 11'd1;

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [SLOT_W-1:0]       slot;
        logic [PTR_W-1:0]        pointer_value;
        logic [ROW_W-1:0]        entry_row;
        logic signed [VAL_W-1:0] entry_value;
        logic [IDX_W-1:0]        start_index;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0] best_row;
        logic [IDX_W-1:0] best_col;
        logic             sign_negative;
        logic             status;
    } t_out_word;

    typedef enum logic [1:0] {
        LK_AA,
        LK_AK,
        LK_KA,
        LK_KK
    } t_lk_sel;

    typedef enum logic [1:0] {
        MUL_DIAG,
        MUL_PLUS,
        MUL_MINUS
    } t_mul_mode;

    typedef struct packed {
        logic      take;
        logic      init_ok;
        logic      init_bad;
        logic      init_pass2;
        logic      lk_go;
        t_lk_sel   lk_sel;
        logic      mul_go;
        t_mul_mode mul_mode;
        logic      offer;
        logic      offer_neg;
        logic      next_k;
        logic      load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic s_bad;
        logic k_done;
        logic k_is_anchor;
        logic pass2;
        logic lk_done;
        logic out_free;
    } t_dp_status;

endpackage

// ===== sv/sparse_pair_argmin_search.sv =====
`timescale 1ns / 1ps
// Load words leave the controller idle; a start word out of range skips the search.
// A search runs a column pass and then a row pass; each candidate other than the anchor needs three
// lookups, each a binary search over the n entries in the column searched.
// One word is worked on at a time; the next is taken once the result sits in the output register.
// Synchronous active-low reset clears the controller, the output valid and the configuration;
// the matrix memories are not cleared and hold nothing meaningful until written.
// ----------------------------------------------------------------------------
// Sparse pair argmin search: top level
// Joins the controller and the datapath to the word, result and
// configuration ports.
// ----------------------------------------------------------------------------
module sparse_pair_argmin_search import spas_pkg::*; #(
    parameter int MAX_DIM = 1024,
    parameter int MAX_NNZ = 16384
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_ctrl_cmd  cmd;
    t_dp_status status;
    logic       idle;

    spas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_is_start (i_in_word.op == OP_START),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_idle     (idle)
    );

    spas_dpath #(
        .MAX_DIM (MAX_DIM),
        .MAX_NNZ (MAX_NNZ)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

    assign o_in_stall = !idle;

endmodule

// ===== sv/spas_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse pair argmin search: matrix store and element lookup
// Holds the column pointer and entry memories and finds G(r,c) by a binary
// search over the entries of column c, returning zero when the row is absent or c is out of range.
// ----------------------------------------------------------------------------
module spas_lookup import spas_pkg::*; #(
    parameter int MAX_DIM = 1024,
    parameter int MAX_NNZ = 16384
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_ptr_we,
    input  logic                    i_ent_we,
    input  logic [SLOT_W-1:0]       i_wr_slot,
    input  logic [PTR_W-1:0]        i_ptr_data,
    input  logic [ROW_W-1:0]        i_ent_row,
    input  logic signed [VAL_W-1:0] i_ent_val,
    input  logic                    i_start,
    input  logic [IDX_W-1:0]        i_r,
    input  logic [IDX_W-1:0]        i_c,
    input  logic [IDX_W-1:0]        i_cols,
    output logic                    o_done,
    output logic signed [VAL_W-1:0] o_val
);

    localparam int PA = $clog2(MAX_DIM + 1);
    localparam int EA = (MAX_NNZ > 1) ? $clog2(MAX_NNZ) : 1;
    localparam int CW = $clog2(MAX_NNZ + 1);

    typedef enum logic [4:0] {
        L_IDLE = 5'b00001,
        L_RD0  = 5'b00010,
        L_RD1  = 5'b00100,
        L_SRCH = 5'b01000,
        L_CMP  = 5'b10000
    } t_lk_state;

    logic [PTR_W-1:0]        ptr_mem [MAX_DIM+1];
    logic [ROW_W-1:0]        row_mem [MAX_NNZ];
    logic signed [VAL_W-1:0] val_mem [MAX_NNZ];

    t_lk_state               r_state, n_state;
    logic [IDX_W-1:0]        r_r, n_r, r_c, n_c;
    logic [CW-1:0]           r_lo, n_lo, r_e, n_e, r_mid, n_mid;
    logic                    r_done, n_done;
    logic signed [VAL_W-1:0] r_val, n_val;
    logic [PTR_W-1:0]        r_ptr_q;
    logic [ROW_W-1:0]        r_row_q;
    logic signed [VAL_W-1:0] r_val_q;

    logic [31:0]      slot_w, ptr_ra_w, ent_ra_w;
    logic [CW-1:0]    p_cl, mid;
    logic [IDX_W-1:0] rr;
    logic             ptr_ok, ent_ok;

    assign slot_w = 32'(i_wr_slot);
    assign ptr_ok = slot_w <= 32'(MAX_DIM);
    assign ent_ok = slot_w < 32'(MAX_NNZ);
    assign ptr_ra_w = (r_state == L_IDLE) ? (32'(i_c) - 32'd1) : 32'(r_c);
    assign mid = r_lo + ((r_e - r_lo - CW'(1)) >> 1);
    assign ent_ra_w = 32'(mid);
    assign p_cl = (32'(r_ptr_q) > 32'(MAX_NNZ)) ? CW'(MAX_NNZ) : CW'(r_ptr_q);
    assign rr = IDX_W'(r_row_q) + IDX_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_ptr_we && ptr_ok) begin
            ptr_mem[slot_w[PA-1:0]] <= i_ptr_data;
        end
        if (i_ent_we && ent_ok) begin
            row_mem[slot_w[EA-1:0]] <= i_ent_row;
            val_mem[slot_w[EA-1:0]] <= i_ent_val;
        end
        r_ptr_q <= ptr_mem[ptr_ra_w[PA-1:0]];
        r_row_q <= row_mem[ent_ra_w[EA-1:0]];
        r_val_q <= val_mem[ent_ra_w[EA-1:0]];
    end

    always_comb begin
        n_state = r_state;
        n_r     = r_r;
        n_c     = r_c;
        n_lo    = r_lo;
        n_e     = r_e;
        n_mid   = r_mid;
        n_done  = 1'b0;
        n_val   = r_val;
        case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    n_r = i_r;
                    n_c = i_c;
                    if (i_c == '0 || i_c > i_cols) begin
                        n_val  = '0;
                        n_done = 1'b1;
                    end else begin
                        n_state = L_RD0;
                    end
                end
            end
            L_RD0: begin
                n_lo    = p_cl;
                n_state = L_RD1;
            end
            L_RD1: begin
                n_e     = p_cl;
                n_state = L_SRCH;
            end
            L_SRCH: begin
                if (r_lo < r_e) begin
                    n_mid   = mid;
                    n_state = L_CMP;
                end else begin
                    n_val   = '0;
                    n_done  = 1'b1;
                    n_state = L_IDLE;
                end
            end
            L_CMP: begin
                if (rr == r_r) begin
                    n_val   = r_val_q;
                    n_done  = 1'b1;
                    n_state = L_IDLE;
                end else begin
                    if (rr > r_r) begin
                        n_e = r_mid;
                    end else begin
                        n_lo = r_mid + CW'(1);
                    end
                    n_state = L_SRCH;
                end
            end
            default: begin
                n_state = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_r   <= n_r;
        r_c   <= n_c;
        r_lo  <= n_lo;
        r_e   <= n_e;
        r_mid <= n_mid;
        r_val <= n_val;
    end

    assign o_done = r_done;
    assign o_val  = r_val;

endmodule

// ===== sv/spas_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse pair argmin search: datapath
// Configuration registers, candidate index counters, fetched matrix values,
// score multiplier, running minimum and the output register.
// ----------------------------------------------------------------------------
module spas_dpath import spas_pkg::*; #(
    parameter int MAX_DIM = 1024,
    parameter int MAX_NNZ = 16384
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_word              i_in_word,
    input  logic                  i_out_stall,
    input  t_ctrl_cmd             i_cmd,
    output t_dp_status            o_status,
    output logic                  o_out_valid,
    output t_out_word             o_out_word
);

    logic signed [LAM_W-1:0]   r_lam;
    logic [IDX_W-1:0]          r_rows, r_cols;
    logic [IDX_W-1:0]          r_s, r_anchor;
    logic [K_W-1:0]            r_k;
    logic                      r_pass2;
    logic signed [VAL_W-1:0]   r_gd, r_g1, r_g2, r_g3;
    t_lk_sel                   r_lk_sel;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [SCORE_W-1:0] r_best;
    logic [IDX_W-1:0]          r_brow, r_bcol;
    logic                      r_sign, r_stat;
    logic                      r_out_valid;
    t_out_word                 r_out;

    logic [IDX_W-1:0]        rows_eff, cols_eff, limit, k_idx, lk_r, lk_c;
    logic signed [SUM_W-1:0] sum_sel;
    logic                    lk_done, better;
    logic signed [VAL_W-1:0] lk_val;

    assign rows_eff = (32'(r_rows) > 32'(MAX_DIM)) ? IDX_W'(MAX_DIM) : r_rows;
    assign cols_eff = (32'(r_cols) > 32'(MAX_DIM)) ? IDX_W'(MAX_DIM) : r_cols;
    assign limit    = r_pass2 ? rows_eff : cols_eff;
    assign k_idx    = r_k[IDX_W-1:0];

    always_comb begin
        case (i_cmd.lk_sel)
            LK_AA: begin
                lk_r = r_anchor;
                lk_c = r_anchor;
            end
            LK_AK: begin
                lk_r = r_anchor;
                lk_c = k_idx;
            end
            LK_KA: begin
                lk_r = k_idx;
                lk_c = r_anchor;
            end
            default: begin
                lk_r = k_idx;
                lk_c = k_idx;
            end
        endcase
    end

    spas_lookup #(
        .MAX_DIM (MAX_DIM),
        .MAX_NNZ (MAX_NNZ)
    ) u_lookup (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ptr_we   (i_cmd.take && i_in_word.op == OP_LOAD_PTR),
        .i_ent_we   (i_cmd.take && i_in_word.op == OP_LOAD_ENTRY),
        .i_wr_slot  (i_in_word.slot),
        .i_ptr_data (i_in_word.pointer_value),
        .i_ent_row  (i_in_word.entry_row),
        .i_ent_val  (i_in_word.entry_value),
        .i_start    (i_cmd.lk_go),
        .i_r        (lk_r),
        .i_c        (lk_c),
        .i_cols     (cols_eff),
        .o_done     (lk_done),
        .o_val      (lk_val)
    );

    always_comb begin
        case (i_cmd.mul_mode)
            MUL_PLUS:  sum_sel = SUM_W'(r_gd) + SUM_W'(r_g1) + SUM_W'(r_g2) + SUM_W'(r_g3);
            MUL_MINUS: sum_sel = SUM_W'(r_gd) - SUM_W'(r_g1) - SUM_W'(r_g2) + SUM_W'(r_g3);
            default:   sum_sel = SUM_W'(r_gd);
        endcase
    end

    assign better = SCORE_W'(r_prod) < r_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lam       <= LAMBDA_RESET;
            r_rows      <= DIM_RESET;
            r_cols      <= DIM_RESET;
            r_out_valid <= 1'b0;
            r_best      <= SCORE_MAX;
            r_brow      <= IDX_ONE;
            r_bcol      <= IDX_ONE;
            r_sign      <= 1'b0;
            r_stat      <= 1'b0;
            r_pass2     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LAMBDA: r_lam  <= i_cfg_data;
                    CFG_ROWS:   r_rows <= i_cfg_data[IDX_W-1:0];
                    CFG_COLS:   r_cols <= i_cfg_data[IDX_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.init_ok || i_cmd.init_bad) begin
                r_best  <= SCORE_MAX;
                r_brow  <= i_cmd.init_ok ? r_s : IDX_ONE;
                r_bcol  <= IDX_ONE;
                r_sign  <= 1'b0;
                r_stat  <= i_cmd.init_bad;
                r_pass2 <= 1'b0;
            end else if (i_cmd.init_pass2) begin
                r_pass2 <= 1'b1;
            end else if (i_cmd.offer && better) begin
                r_best <= SCORE_W'(r_prod);
                r_sign <= i_cmd.offer_neg;
                if (r_pass2) begin
                    r_brow <= k_idx;
                end else begin
                    r_bcol <= k_idx;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_s <= i_in_word.start_index;
        end
        if (i_cmd.init_ok) begin
            r_anchor <= r_s;
            r_k      <= K_W'(1);
        end else if (i_cmd.init_pass2) begin
            r_anchor <= r_bcol;
            r_k      <= K_W'(1);
        end else if (i_cmd.next_k) begin
            r_k <= r_k + K_W'(1);
        end
        if (i_cmd.lk_go) begin
            r_lk_sel <= i_cmd.lk_sel;
        end
        if (lk_done) begin
            case (r_lk_sel)
                LK_AA:   r_gd <= lk_val;
                LK_AK:   r_g1 <= lk_val;
                LK_KA:   r_g2 <= lk_val;
                default: r_g3 <= lk_val;
            endcase
        end
        if (i_cmd.mul_go) begin
            r_prod <= PROD_W'(r_lam) * PROD_W'(sum_sel);
        end
        if (i_cmd.load_out) begin
            r_out.best_row      <= r_brow;
            r_out.best_col      <= r_bcol;
            r_out.sign_negative <= r_sign;
            r_out.status        <= r_stat;
        end
    end

    assign o_status.s_bad       = (r_s == '0) || (r_s > rows_eff);
    assign o_status.k_done      = r_k > K_W'(limit);
    assign o_status.k_is_anchor = r_k == K_W'(r_anchor);
    assign o_status.pass2       = r_pass2;
    assign o_status.lk_done     = lk_done;
    assign o_status.out_free    = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

// ===== sv/spas_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse pair argmin search: controller
// Sequences the range check, the column pass, the row pass and the hand-over
// of the result to the output register.
// ----------------------------------------------------------------------------
module spas_ctrl import spas_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_is_start,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd,
    output logic       o_idle
);

    typedef enum logic [17:0] {
        S_IDLE    = 18'h00001,
        S_CHECK   = 18'h00002,
        S_BASE_GO = 18'h00004,
        S_BASE_WT = 18'h00008,
        S_K_TEST  = 18'h00010,
        S_AK_GO   = 18'h00020,
        S_AK_WT   = 18'h00040,
        S_KA_GO   = 18'h00080,
        S_KA_WT   = 18'h00100,
        S_KK_GO   = 18'h00200,
        S_KK_WT   = 18'h00400,
        S_MUL_D   = 18'h00800,
        S_CMP_D   = 18'h01000,
        S_MUL_P   = 18'h02000,
        S_CMP_P   = 18'h04000,
        S_MUL_M   = 18'h08000,
        S_CMP_M   = 18'h10000,
        S_FINISH  = 18'h20000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_is_start) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (i_status.s_bad) begin
                    o_cmd.init_bad = 1'b1;
                    n_state        = S_FINISH;
                end else begin
                    o_cmd.init_ok = 1'b1;
                    n_state       = S_BASE_GO;
                end
            end
            S_BASE_GO: begin
                o_cmd.lk_go  = 1'b1;
                o_cmd.lk_sel = LK_AA;
                n_state      = S_BASE_WT;
            end
            S_BASE_WT: begin
                if (i_status.lk_done) begin
                    n_state = S_K_TEST;
                end
            end
            S_K_TEST: begin
                if (i_status.k_done) begin
                    if (i_status.pass2) begin
                        n_state = S_FINISH;
                    end else begin
                        o_cmd.init_pass2 = 1'b1;
                        n_state          = S_BASE_GO;
                    end
                end else if (i_status.k_is_anchor) begin
                    n_state = S_MUL_D;
                end else begin
                    n_state = S_AK_GO;
                end
            end
            S_AK_GO: begin
                o_cmd.lk_go  = 1'b1;
                o_cmd.lk_sel = LK_AK;
                n_state      = S_AK_WT;
            end
            S_AK_WT: begin
                if (i_status.lk_done) begin
                    n_state = S_KA_GO;
                end
            end
            S_KA_GO: begin
                o_cmd.lk_go  = 1'b1;
                o_cmd.lk_sel = LK_KA;
                n_state      = S_KA_WT;
            end
            S_KA_WT: begin
                if (i_status.lk_done) begin
                    n_state = S_KK_GO;
                end
            end
            S_KK_GO: begin
                o_cmd.lk_go  = 1'b1;
                o_cmd.lk_sel = LK_KK;
                n_state      = S_KK_WT;
            end
            S_KK_WT: begin
                if (i_status.lk_done) begin
                    n_state = S_MUL_P;
                end
            end
            S_MUL_D: begin
                o_cmd.mul_go   = 1'b1;
                o_cmd.mul_mode = MUL_DIAG;
                n_state        = S_CMP_D;
            end
            S_CMP_D: begin
                o_cmd.offer  = 1'b1;
                o_cmd.next_k = 1'b1;
                n_state      = S_K_TEST;
            end
            S_MUL_P: begin
                o_cmd.mul_go   = 1'b1;
                o_cmd.mul_mode = MUL_PLUS;
                n_state        = S_CMP_P;
            end
            S_CMP_P: begin
                o_cmd.offer = 1'b1;
                n_state     = S_MUL_M;
            end
            S_MUL_M: begin
                o_cmd.mul_go   = 1'b1;
                o_cmd.mul_mode = MUL_MINUS;
                n_state        = S_CMP_M;
            end
            S_CMP_M: begin
                o_cmd.offer     = 1'b1;
                o_cmd.offer_neg = 1'b1;
                o_cmd.next_k    = 1'b1;
                n_state         = S_K_TEST;
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

// ===== sv/spas_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse pair argmin search: port checker
// Watches the top-level ports over time and reports rule breaches.
// ----------------------------------------------------------------------------
module spas_checker import spas_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input t_in_word              i_in_word,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input t_out_word             o_out_word,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word valid straight after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result word changed");

    a_bad_start_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status |->
            o_out_word.best_row == 11'd1 && o_out_word.best_col == 11'd1 &&
            !o_out_word.sign_negative)
        else $error("out of range result carries a pair");

    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.status |->
            o_out_word.best_row != 11'd0 && o_out_word.best_col != 11'd0)
        else $error("result index is zero");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_word.op == OP_START |=> o_in_stall)
        else $error("new word taken while a search runs");

endmodule

bind sparse_pair_argmin_search spas_checker u_spas_checker (.*);
